### hdl/kana_to_romaji_transliterator_assert.svh
// Assertion macros shared by the transliterator RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef KANA_TO_ROMAJI_TRANSLITERATOR_ASSERT_SVH
`define KANA_TO_ROMAJI_TRANSLITERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define KR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/kr_pkg.sv
// Types, constants and kana tables for the transliterator.
// No dependencies.
package kr_pkg;

  localparam logic [20:0] KANA_BASE  = 21'h3040;
  localparam logic [20:0] KANA_TOP   = 21'h3096;
  localparam logic [20:0] SMALL_TSU  = 21'h3063;
  localparam logic [20:0] SYLLABIC_N = 21'h3093;
  localparam logic [20:0] WIDE_SHIFT = 21'hFEE0;
  localparam logic [20:0] WIDE_BLANK = 21'h3000;
  localparam logic [20:0] PRINT_LO   = 21'h21;
  localparam logic [20:0] PRINT_HI   = 21'h7E;
  localparam logic [20:0] ASCII_BLANK = 21'h20;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_WIDE   = 2'd1;
  localparam logic [1:0] MODE_NARROW = 2'd2;

  localparam int NSEG = 6;
  localparam int SLOT_BODY = 3;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][6:0] ch;
  } seg_t;

  typedef struct packed {
    seg_t [NSEG-1:0] seg;
    logic            pt;
    logic [20:0]     cp;
    logic            last;
  } cmd_t;

  function automatic seg_t mk1(input logic [7:0] s);
    seg_t r;
    r = '0;
    r.len = 2'd1;
    r.ch[0] = s[6:0];
    return r;
  endfunction

  function automatic seg_t mk2(input logic [15:0] s);
    seg_t r;
    r = '0;
    r.len = 2'd2;
    r.ch[0] = s[14:8];
    r.ch[1] = s[6:0];
    return r;
  endfunction

  function automatic seg_t mk3(input logic [23:0] s);
    seg_t r;
    r.len = 2'd3;
    r.ch[0] = s[22:16];
    r.ch[1] = s[14:8];
    r.ch[2] = s[6:0];
    return r;
  endfunction

  localparam seg_t SEG_XTU = mk3("xtu");
  localparam seg_t SEG_NN  = mk2("nn");

  function automatic seg_t single_entry(input logic [6:0] off);
    seg_t r;
    case (off)
      7'd1: r = mk2("xa");   7'd2: r = mk1("a");    7'd3: r = mk2("xi");
      7'd4: r = mk1("i");    7'd5: r = mk2("xu");   7'd6: r = mk1("u");
      7'd7: r = mk2("xe");   7'd8: r = mk1("e");    7'd9: r = mk2("xo");
      7'd10: r = mk1("o");   7'd11: r = mk2("ka");  7'd12: r = mk2("ga");
      7'd13: r = mk2("ki");  7'd14: r = mk2("gi");  7'd15: r = mk2("ku");
      7'd16: r = mk2("gu");  7'd17: r = mk2("ke");  7'd18: r = mk2("ge");
      7'd19: r = mk2("ko");  7'd20: r = mk2("go");  7'd21: r = mk2("sa");
      7'd22: r = mk2("za");  7'd23: r = mk3("shi"); 7'd24: r = mk2("ji");
      7'd25: r = mk2("su");  7'd26: r = mk2("zu");  7'd27: r = mk2("se");
      7'd28: r = mk2("ze");  7'd29: r = mk2("so");  7'd30: r = mk2("zo");
      7'd31: r = mk2("ta");  7'd32: r = mk2("da");  7'd33: r = mk3("chi");
      7'd34: r = mk2("di");  7'd36: r = mk3("tsu"); 7'd37: r = mk2("du");
      7'd38: r = mk2("te");  7'd39: r = mk2("de");  7'd40: r = mk2("to");
      7'd41: r = mk2("do");  7'd42: r = mk2("na");  7'd43: r = mk2("ni");
      7'd44: r = mk2("nu");  7'd45: r = mk2("ne");  7'd46: r = mk2("no");
      7'd47: r = mk2("ha");  7'd48: r = mk2("ba");  7'd49: r = mk2("pa");
      7'd50: r = mk2("hi");  7'd51: r = mk2("bi");  7'd52: r = mk2("pi");
      7'd53: r = mk2("fu");  7'd54: r = mk2("bu");  7'd55: r = mk2("pu");
      7'd56: r = mk2("he");  7'd57: r = mk2("be");  7'd58: r = mk2("pe");
      7'd59: r = mk2("ho");  7'd60: r = mk2("bo");  7'd61: r = mk2("po");
      7'd62: r = mk2("ma");  7'd63: r = mk2("mi");  7'd64: r = mk2("mu");
      7'd65: r = mk2("me");  7'd66: r = mk2("mo");  7'd67: r = mk3("xya");
      7'd68: r = mk2("ya");  7'd69: r = mk3("xyu"); 7'd70: r = mk2("yu");
      7'd71: r = mk3("xyo"); 7'd72: r = mk2("yo");  7'd73: r = mk2("ra");
      7'd74: r = mk2("ri");  7'd75: r = mk2("ru");  7'd76: r = mk2("re");
      7'd77: r = mk2("ro");  7'd78: r = mk3("xwa"); 7'd79: r = mk2("wa");
      7'd82: r = mk2("wo");  7'd84: r = mk2("vu");
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        ygrp;
    logic        egrp;
    logic        vgrp;
    logic        wgrp;
    logic        yegrp;
    logic [1:0]  sl;
    logic [15:0] st;
  } stem_t;

  function automatic stem_t stem_of(input logic [6:0] first);
    stem_t r;
    r = '0;
    case (first)
      7'd13: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "ky"; end
      7'd14: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "gy"; end
      7'd23: begin r.ygrp = 1'b1; r.egrp = 1'b1; r.sl = 2'd2; r.st = "sh"; end
      7'd24: begin r.ygrp = 1'b1; r.egrp = 1'b1; r.sl = 2'd1; r.st = "j"; end
      7'd33: begin r.ygrp = 1'b1; r.egrp = 1'b1; r.sl = 2'd2; r.st = "ch"; end
      7'd34: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "dy"; end
      7'd43: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "ny"; end
      7'd50: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "hy"; end
      7'd51: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "by"; end
      7'd52: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "py"; end
      7'd63: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "my"; end
      7'd74: begin r.ygrp = 1'b1; r.sl = 2'd2; r.st = "ry"; end
      7'd53: begin r.vgrp = 1'b1; r.sl = 2'd1; r.st = "f"; end
      7'd84: begin r.vgrp = 1'b1; r.sl = 2'd1; r.st = "v"; end
      7'd36: begin r.vgrp = 1'b1; r.sl = 2'd2; r.st = "ts"; end
      7'd6:  begin r.wgrp = 1'b1; r.sl = 2'd1; r.st = "w"; end
      7'd4:  begin r.yegrp = 1'b1; r.sl = 2'd1; r.st = "y"; end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic can_start(input logic [6:0] off);
    stem_t s;
    s = stem_of(off);
    return s.ygrp | s.vgrp | s.wgrp | s.yegrp;
  endfunction

  function automatic seg_t pair_entry(input logic [6:0] first, input logic [6:0] second);
    stem_t s;
    seg_t r;
    logic [7:0] v;
    logic ysec, vsec, ok;
    s = stem_of(first);
    r = '0;
    case (second)
      7'd67, 7'd1: v = "a";
      7'd3:        v = "i";
      7'd69:       v = "u";
      7'd7:        v = "e";
      7'd71, 7'd9: v = "o";
      default:     v = 8'd0;
    endcase
    ysec = (second == 7'd67) || (second == 7'd69) || (second == 7'd71);
    vsec = (second == 7'd1) || (second == 7'd3) || (second == 7'd7) || (second == 7'd9);
    ok = (s.ygrp & ysec) | (s.egrp & (second == 7'd7)) | (s.vgrp & vsec)
       | (s.wgrp & ((second == 7'd3) || (second == 7'd7)))
       | (s.yegrp & (second == 7'd7));
    if (ok) begin
      if (s.sl == 2'd1) begin
        r.len = 2'd2;
        r.ch[0] = s.st[6:0];
        r.ch[1] = v[6:0];
      end else begin
        r.len = 2'd3;
        r.ch[0] = s.st[14:8];
        r.ch[1] = s.st[6:0];
        r.ch[2] = v[6:0];
      end
    end
    return r;
  endfunction

  function automatic seg_t prefix(input logic pend, input seg_t e);
    seg_t r;
    logic vow;
    r = '0;
    vow = (e.ch[0] == 7'h61) || (e.ch[0] == 7'h69) || (e.ch[0] == 7'h75)
       || (e.ch[0] == 7'h65) || (e.ch[0] == 7'h6F);
    if (pend) begin
      if (vow) begin
        r = SEG_XTU;
      end else begin
        r.len = 2'd1;
        r.ch[0] = e.ch[0];
      end
    end
    return r;
  endfunction

  function automatic logic [20:0] width_map(input logic [1:0] mode, input logic [20:0] c);
    logic [20:0] r;
    r = c;
    case (mode)
      MODE_WIDE: begin
        if (c == ASCII_BLANK) r = WIDE_BLANK;
        else if (c >= PRINT_LO && c <= PRINT_HI) r = c + WIDE_SHIFT;
      end
      MODE_NARROW: begin
        if (c == WIDE_BLANK) r = ASCII_BLANK;
        else if (c >= PRINT_LO + WIDE_SHIFT && c <= PRINT_HI + WIDE_SHIFT) r = c - WIDE_SHIFT;
      end
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

### hdl/kr_front.sv
// Front end: accepts characters, tracks held kana and sokuon, builds segment lists.
// Depends on kr_pkg.
module kr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [20:0]   code_point,
  input  logic          last_char,
  input  logic          q_full,
  output logic          q_push,
  output kr_pkg::cmd_t  q_cmd
);
  import kr_pkg::*;

  logic       sokuon, held;
  logic [6:0] held_off;
  logic       sokuon_next, held_next;
  logic [6:0] held_off_next;
  logic       is_kana, consumed;
  logic [6:0] off, off_k;
  seg_t       e_held, p_held, e_cur;

  assign is_kana = (code_point >= KANA_BASE) && (code_point <= KANA_TOP);
  assign off     = 7'(code_point - KANA_BASE);
  assign off_k   = is_kana ? off : 7'h7F;
  assign e_held  = single_entry(held_off);
  assign p_held  = pair_entry(held_off, off_k);
  assign e_cur   = single_entry(off);
  assign q_push  = push & ~q_full;

  always_comb begin
    q_cmd = '0;
    q_cmd.cp = code_point;
    q_cmd.last = last_char;
    sokuon_next = sokuon;
    held_next = 1'b0;
    held_off_next = '0;
    consumed = 1'b0;
    if (held) begin
      if (p_held.len != 2'd0) begin
        q_cmd.seg[0] = prefix(sokuon_next, p_held);
        q_cmd.seg[1] = p_held;
        consumed = 1'b1;
      end else begin
        q_cmd.seg[0] = prefix(sokuon_next, e_held);
        q_cmd.seg[1] = e_held;
      end
      sokuon_next = 1'b0;
    end
    if (!consumed) begin
      if (code_point == SMALL_TSU) begin
        if (sokuon_next) q_cmd.seg[2] = SEG_XTU;
        sokuon_next = 1'b1;
      end else if (code_point == SYLLABIC_N) begin
        if (sokuon_next) q_cmd.seg[2] = SEG_XTU;
        q_cmd.seg[SLOT_BODY] = SEG_NN;
        sokuon_next = 1'b0;
      end else if (is_kana && e_cur.len != 2'd0) begin
        if (can_start(off)) begin
          held_next = 1'b1;
          held_off_next = off;
        end else begin
          q_cmd.seg[2] = prefix(sokuon_next, e_cur);
          q_cmd.seg[SLOT_BODY] = e_cur;
          sokuon_next = 1'b0;
        end
      end else begin
        if (sokuon_next) q_cmd.seg[2] = SEG_XTU;
        q_cmd.seg[SLOT_BODY].len = 2'd1;
        q_cmd.pt = 1'b1;
        sokuon_next = 1'b0;
      end
    end
    if (last_char) begin
      if (held_next) begin
        q_cmd.seg[4] = prefix(sokuon_next, e_cur);
        q_cmd.seg[5] = e_cur;
      end else if (sokuon_next) begin
        q_cmd.seg[4] = SEG_XTU;
      end
      sokuon_next = 1'b0;
      held_next = 1'b0;
      held_off_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sokuon <= 1'b0;
      held <= 1'b0;
      held_off <= '0;
    end else if (q_push) begin
      sokuon <= sokuon_next;
      held <= held_next;
      held_off <= held_off_next;
    end
  end

endmodule

### hdl/kr_queue.sv
// Short queue of segment lists between front and back end.
// Depends on kr_pkg.
module kr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  kr_pkg::cmd_t  wdata,
  input  logic          rd,
  output kr_pkg::cmd_t  rdata,
  output logic          full,
  output logic          empty
);
  import kr_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  cmd_t          mem [QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

### hdl/kr_back.sv
// Back end: walks a segment list, one character per beat while no stalled pop holds it, into the output register.
// Depends on kr_pkg.
module kr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    mode,
  input  logic          q_empty,
  input  kr_pkg::cmd_t  q_cmd,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [20:0]   out_code_point,
  output logic          end_of_run,
  output logic          end_of_text
);
  import kr_pkg::*;

  cmd_t        cur;
  logic        busy, ovalid;
  logic [2:0]  slot;
  logic [1:0]  idx;
  logic        adv, nx_found, ld_found;
  logic [2:0]  nx_slot, ld_slot;
  logic [20:0] ch;
  seg_t        seg;

  function automatic logic [3:0] first_nz(input cmd_t c, input logic [3:0] start);
    logic [3:0] r;
    r = 4'b0111;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (4'(i) >= start && c.seg[i].len != 2'd0) r = {1'b1, 3'(i)};
    end
    return r;
  endfunction

  assign seg = cur.seg[slot];
  assign ch  = (slot == 3'(SLOT_BODY) && cur.pt) ? cur.cp : {14'b0, seg.ch[idx]};
  assign {nx_found, nx_slot} = first_nz(cur, {1'b0, slot} + 4'd1);
  assign {ld_found, ld_slot} = first_nz(q_cmd, 4'd0);
  assign adv   = ~ovalid | pop;
  assign q_pop = ~busy & ~q_empty;
  assign empty = ~ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (busy && adv) begin
        ovalid <= 1'b1;
        if (idx + 2'd1 < seg.len) begin
          idx <= idx + 2'd1;
        end else if (nx_found) begin
          slot <= nx_slot;
          idx <= '0;
        end else begin
          busy <= 1'b0;
        end
      end else if (adv) begin
        ovalid <= 1'b0;
      end
      if (q_pop) begin
        cur <= q_cmd;
        busy <= ld_found;
        slot <= ld_slot;
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      out_code_point <= width_map(mode, ch);
      end_of_run <= ~(idx + 2'd1 < seg.len) & ~nx_found;
      end_of_text <= ~(idx + 2'd1 < seg.len) & ~nx_found & cur.last;
    end
  end

endmodule

### hdl/kana_to_romaji_transliterator.sv
// Top level of the kana to romaji transliterator.
// Depends on kr_pkg, kr_front, kr_queue, kr_back and the assertion header.
//
// channel  direction  handshake        payload
// input    in         push / full      code_point, last_char
// result   out        pop / empty      out_code_point, end_of_run, end_of_text
// config   in         cfg_we           cfg_wdata (output mode)
//
// Front end takes one character per cycle while the four-entry queue has room.
// Back end loads a queue entry, then emits its characters in turn, and takes
// the next entry only once it is done with the current one.
// Items that produce nothing are dropped at load. rst clears state and the mode.
// A stalled pop holds the output register; the queue then fills and raises full.
module kana_to_romaji_transliterator (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [20:0] code_point,
  input  logic        last_char,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] out_code_point,
  output logic        end_of_run,
  output logic        end_of_text,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  import kr_pkg::*;

  logic [1:0] mode;
  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_wcmd, q_rcmd;

  always_ff @(posedge clk) begin
    if (rst) mode <= MODE_PLAIN;
    else if (cfg_we) mode <= cfg_wdata;
  end

  assign full = q_full;

  kr_front u_front (
    .clk(clk), .rst(rst), .push(push), .code_point(code_point),
    .last_char(last_char), .q_full(q_full), .q_push(q_push), .q_cmd(q_wcmd)
  );

  kr_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(q_wcmd), .rd(q_pop),
    .rdata(q_rcmd), .full(q_full), .empty(q_empty)
  );

  kr_back u_back (
    .clk(clk), .rst(rst), .mode(mode), .q_empty(q_empty), .q_cmd(q_rcmd),
    .q_pop(q_pop), .pop(pop), .empty(empty), .out_code_point(out_code_point),
    .end_of_run(end_of_run), .end_of_text(end_of_text)
  );

`include "kana_to_romaji_transliterator_assert.svh"

  `KR_ASSERT_IMPLY(a_eot_ends_run, !empty && end_of_text, end_of_run)
  `KR_ASSERT_IMPLY(a_wide_no_ascii, !empty && mode == MODE_WIDE,
    out_code_point < PRINT_LO || out_code_point > PRINT_HI)
  `KR_ASSERT_NEXT(a_pop_frees_queue, q_full && !q_pop, q_full)

endmodule
